// ----- sv/rmbn_pkg.sv -----
// Package: beat types for the normal-to-normal rotation matrix block.
`default_nettype none
package rmbn_pkg;

  // fractional bits of the internal fixed-point format
  localparam int QBITS = 30;

  typedef struct packed {
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;
  } mat_t;

endpackage
`default_nettype wire

// ----- sv/rotation_matrix_between_normals.sv -----
// Top level: pipelined axis-angle rotation matrix between two vectors.
// Pipeline: 108 register stages from the accepting edge to done.
// Throughput: one beat per cycle; busy is always low.
// Most of them are two 32-step square root sections in series (three roots) and a 31-step divider.
// Results cannot be stalled; each is shown for exactly one cycle.
// Synchronous reset clears all valid bits and sets flip_obtuse to 1.
`default_nettype none
module rotation_matrix_between_normals
  import rmbn_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire vec_t vec,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  output logic      done,
  output mat_t      result
);

  localparam int SQ_STAGES = 32;
  localparam int DV_STAGES = QBITS + 1;
  localparam int SH = QBITS - FRAC_BITS;
  localparam logic [35:0] HALF = (SH == 0) ? 36'd0 : (36'd1 << (SH - 1));
  localparam longint ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [36:0] HI = 37'((ONE < 64'sd32767) ? ONE : 64'sd32767);
  localparam logic signed [36:0] LO = 37'((ONE < 64'sd32768) ? -ONE : -64'sd32768);
  localparam logic [63:0] Q60 = 64'd1 << (2 * QBITS);
  localparam logic signed [32:0] Q30S = 33'sd1 <<< QBITS;

  // qmul rounding: half away from zero, drop QBITS bits
  function automatic logic signed [35:0] rnd30(input logic signed [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + (64'd1 << (QBITS - 1))) >> QBITS;
    return x[63] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  // Q30 entry to output format with saturation
  function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
    logic [35:0] m;
    logic [35:0] r;
    logic signed [36:0] sv;
    m = v[35] ? 36'(-v) : 36'(v);
    r = (m + HALF) >> SH;
    sv = v[35] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (sv > HI) sv = HI;
    if (sv < LO) sv = LO;
    return 16'(sv);
  endfunction

  typedef struct packed {
    logic              degen;
    logic              ds;
    logic [31:0]       dm;
    logic [2:0]        us;
    logic [2:0][31:0]  um;
  } sq1_side_t;

  typedef struct packed {
    logic       degen;
    logic       ds;
    logic [2:0] us;
  } dv_side_t;

  typedef struct packed {
    logic                     degen;
    logic signed [31:0]       c;
    logic signed [32:0]       co;
    logic [2:0][31:0]         k;
    logic [5:0][35:0]         p;
  } sq2_side_t;

  assign busy = 1'b0;

  // configuration register
  logic flip_obtuse;
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_obtuse <= 1'b1;
    end else if (cfg_we) begin
      flip_obtuse <= cfg_wdata;
    end
  end

  // input components as arrays: a = base, b = rot
  logic signed [15:0] a_in [3];
  logic signed [15:0] b_in [3];
  always_comb begin
    a_in[0] = vec.base_x; a_in[1] = vec.base_y; a_in[2] = vec.base_z;
    b_in[0] = vec.rot_x;  b_in[1] = vec.rot_y;  b_in[2] = vec.rot_z;
  end

  // stage 1: all pairwise products and squares
  logic               s1_valid;
  logic signed [31:0] s1_p  [3][3];
  logic signed [31:0] s1_aa [3];
  logic signed [31:0] s1_bb [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_p[i][j] <= b_in[i] * a_in[j];
      end
      s1_aa[i] <= a_in[i] * a_in[i];
      s1_bb[i] <= b_in[i] * b_in[i];
    end
  end

  // stage 2: dot, cross and squared norms
  logic               s2_valid;
  logic signed [33:0] s2_d;
  logic signed [32:0] s2_u [3];
  logic [31:0]        s2_na2;
  logic [31:0]        s2_nb2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_d    <= 34'(s1_p[0][0]) + 34'(s1_p[1][1]) + 34'(s1_p[2][2]);
    s2_u[0] <= 33'(s1_p[1][2]) - 33'(s1_p[2][1]);
    s2_u[1] <= 33'(s1_p[2][0]) - 33'(s1_p[0][2]);
    s2_u[2] <= 33'(s1_p[0][1]) - 33'(s1_p[1][0]);
    s2_na2  <= 32'(s1_aa[0]) + 32'(s1_aa[1]) + 32'(s1_aa[2]);
    s2_nb2  <= 32'(s1_bb[0]) + 32'(s1_bb[1]) + 32'(s1_bb[2]);
  end

  // stage 3: obtuse flip as sign and magnitude, degenerate detect
  logic flip_now;
  assign flip_now = flip_obtuse & s2_d[33];
  logic        s3_valid;
  sq1_side_t   s3_side;
  logic [31:0] s3_na2;
  logic [31:0] s3_nb2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_side.degen <= (s2_u[0] == 33'sd0) && (s2_u[1] == 33'sd0) && (s2_u[2] == 33'sd0);
    s3_side.ds    <= s2_d[33] & ~flip_now;
    s3_side.dm    <= 32'(s2_d[33] ? -s2_d : s2_d);
    for (int i = 0; i < 3; i++) begin
      s3_side.us[i] <= s2_u[i][32] ^ flip_now;
      s3_side.um[i] <= 32'(s2_u[i][32] ? -s2_u[i] : s2_u[i]);
    end
    s3_na2 <= s2_na2;
    s3_nb2 <= s2_nb2;
  end

  // stage 4: norm product and squared cross components
  logic        s4_valid;
  sq1_side_t   s4_side;
  logic [63:0] s4_nprod;
  logic [63:0] s4_usq [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_side  <= s3_side;
    s4_nprod <= 64'(s3_na2) * 64'(s3_nb2);
    for (int i = 0; i < 3; i++) begin
      s4_usq[i] <= 64'(s3_side.um[i]) * 64'(s3_side.um[i]);
    end
  end

  // stage 5 feeds the first square root pipeline
  logic      sa_valid [SQ_STAGES + 1];
  sq1_side_t sa_side  [SQ_STAGES + 1];
  logic [63:0] sa_vn [SQ_STAGES + 1];
  logic [63:0] sa_rn [SQ_STAGES + 1];
  logic [63:0] sa_vu [SQ_STAGES + 1];
  logic [63:0] sa_ru [SQ_STAGES + 1];
  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid[0] <= 1'b0;
    end else begin
      sa_valid[0] <= s4_valid;
    end
    sa_side[0] <= s4_side;
    sa_vn[0]   <= s4_nprod;
    sa_rn[0]   <= 64'd0;
    sa_vu[0]   <= s4_usq[0] + s4_usq[1] + s4_usq[2];
    sa_ru[0]   <= 64'd0;
  end

  // norms: one result bit per stage
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqa
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
    logic [63:0] tn;
    logic [63:0] tu;
    assign tn = sa_rn[i] + BITV;
    assign tu = sa_ru[i] + BITV;
    always_ff @(posedge clk) begin
      if (rst) begin
        sa_valid[i + 1] <= 1'b0;
      end else begin
        sa_valid[i + 1] <= sa_valid[i];
      end
      sa_side[i + 1] <= sa_side[i];
      if (sa_vn[i] >= tn) begin
        sa_vn[i + 1] <= sa_vn[i] - tn;
        sa_rn[i + 1] <= (sa_rn[i] >> 1) + BITV;
      end else begin
        sa_vn[i + 1] <= sa_vn[i];
        sa_rn[i + 1] <= sa_rn[i] >> 1;
      end
      if (sa_vu[i] >= tu) begin
        sa_vu[i + 1] <= sa_vu[i] - tu;
        sa_ru[i + 1] <= (sa_ru[i] >> 1) + BITV;
      end else begin
        sa_vu[i + 1] <= sa_vu[i];
        sa_ru[i + 1] <= sa_ru[i] >> 1;
      end
    end
  end

  // divider bank: lane 0 is the cosine, lanes 1..3 the axis
  logic        dv_valid [DV_STAGES + 1];
  dv_side_t    dv_side  [DV_STAGES + 1];
  logic [63:0] dv_rem   [DV_STAGES + 1][4];
  logic [31:0] dv_den   [DV_STAGES + 1][4];
  logic [QBITS:0] dv_q  [DV_STAGES + 1][4];

  // numerators with half the divisor added for rounding
  logic [31:0] nrm_n;
  logic [31:0] nrm_u;
  assign nrm_n = sa_rn[SQ_STAGES][31:0];
  assign nrm_u = sa_ru[SQ_STAGES][31:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sa_valid[SQ_STAGES];
    end
    dv_side[0].degen <= sa_side[SQ_STAGES].degen;
    dv_side[0].ds    <= sa_side[SQ_STAGES].ds;
    dv_side[0].us    <= sa_side[SQ_STAGES].us;
    dv_rem[0][0] <= {2'b00, sa_side[SQ_STAGES].dm, {QBITS{1'b0}}} + 64'(nrm_n >> 1);
    dv_den[0][0] <= nrm_n;
    dv_q[0][0]   <= '0;
    for (int l = 1; l < 4; l++) begin
      dv_rem[0][l] <= {2'b00, sa_side[SQ_STAGES].um[l - 1], {QBITS{1'b0}}}
                      + 64'(nrm_u >> 1);
      dv_den[0][l] <= nrm_u;
      dv_q[0][l]   <= '0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < DV_STAGES; j++) begin : g_dv
    localparam int BPOS = QBITS - j;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j + 1] <= 1'b0;
      end else begin
        dv_valid[j + 1] <= dv_valid[j];
      end
      dv_side[j + 1] <= dv_side[j];
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [63:0] trial;
      assign trial = {32'd0, dv_den[j][l]} << BPOS;
      always_ff @(posedge clk) begin
        dv_den[j + 1][l] <= dv_den[j][l];
        if (dv_rem[j][l] >= trial) begin
          dv_rem[j + 1][l] <= dv_rem[j][l] - trial;
          dv_q[j + 1][l]   <= {dv_q[j][l][QBITS - 1:0], 1'b1};
        end else begin
          dv_rem[j + 1][l] <= dv_rem[j][l];
          dv_q[j + 1][l]   <= {dv_q[j][l][QBITS - 1:0], 1'b0};
        end
      end
    end
  end

  // apply signs to cosine and axis
  logic               pd_valid;
  logic               pd_degen;
  logic signed [31:0] pd_c;
  logic signed [31:0] pd_k [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      pd_valid <= 1'b0;
    end else begin
      pd_valid <= dv_valid[DV_STAGES];
    end
    pd_degen <= dv_side[DV_STAGES].degen;
    pd_c <= dv_side[DV_STAGES].ds ? -$signed({1'b0, dv_q[DV_STAGES][0]})
                                  : $signed({1'b0, dv_q[DV_STAGES][0]});
    for (int i = 0; i < 3; i++) begin
      pd_k[i] <= dv_side[DV_STAGES].us[i] ? -$signed({1'b0, dv_q[DV_STAGES][i + 1]})
                                          : $signed({1'b0, dv_q[DV_STAGES][i + 1]});
    end
  end

  // axis outer products in order 00 11 22 01 02 12, cosine square
  logic               x1_valid;
  logic               x1_degen;
  logic signed [31:0] x1_c;
  logic signed [32:0] x1_co;
  logic signed [31:0] x1_k [3];
  logic signed [63:0] x1_c2;
  logic signed [63:0] x1_pr [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      x1_valid <= 1'b0;
    end else begin
      x1_valid <= pd_valid;
    end
    x1_degen <= pd_degen;
    x1_c     <= pd_c;
    x1_co    <= Q30S - 33'(pd_c);
    x1_k     <= pd_k;
    x1_c2    <= 64'(pd_c) * 64'(pd_c);
    x1_pr[0] <= 64'(pd_k[0]) * 64'(pd_k[0]);
    x1_pr[1] <= 64'(pd_k[1]) * 64'(pd_k[1]);
    x1_pr[2] <= 64'(pd_k[2]) * 64'(pd_k[2]);
    x1_pr[3] <= 64'(pd_k[0]) * 64'(pd_k[1]);
    x1_pr[4] <= 64'(pd_k[0]) * 64'(pd_k[2]);
    x1_pr[5] <= 64'(pd_k[1]) * 64'(pd_k[2]);
  end

  // round products, form the sine radicand; feeds second square root
  logic        sb_valid [SQ_STAGES + 1];
  sq2_side_t   sb_side  [SQ_STAGES + 1];
  logic [63:0] sb_v     [SQ_STAGES + 1];
  logic [63:0] sb_r     [SQ_STAGES + 1];
  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid[0] <= 1'b0;
    end else begin
      sb_valid[0] <= x1_valid;
    end
    sb_side[0].degen <= x1_degen;
    sb_side[0].c     <= x1_c;
    sb_side[0].co    <= x1_co;
    for (int i = 0; i < 3; i++) begin
      sb_side[0].k[i] <= x1_k[i];
    end
    for (int i = 0; i < 6; i++) begin
      sb_side[0].p[i] <= rnd30(x1_pr[i]);
    end
    sb_v[0] <= Q60 - 64'(x1_c2);
    sb_r[0] <= 64'd0;
  end

  // sine: one result bit per stage
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqb
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
    logic [63:0] tv;
    assign tv = sb_r[i] + BITV;
    always_ff @(posedge clk) begin
      if (rst) begin
        sb_valid[i + 1] <= 1'b0;
      end else begin
        sb_valid[i + 1] <= sb_valid[i];
      end
      sb_side[i + 1] <= sb_side[i];
      if (sb_v[i] >= tv) begin
        sb_v[i + 1] <= sb_v[i] - tv;
        sb_r[i + 1] <= (sb_r[i] >> 1) + BITV;
      end else begin
        sb_v[i + 1] <= sb_v[i];
        sb_r[i + 1] <= sb_r[i] >> 1;
      end
    end
  end

  // stage y1: scale by (1 - cos) and by sine
  sq2_side_t sbo;
  assign sbo = sb_side[SQ_STAGES];
  logic               y1_valid;
  logic               y1_degen;
  logic signed [31:0] y1_c;
  logic signed [63:0] y1_tr [6];
  logic signed [63:0] y1_qr [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      y1_valid <= 1'b0;
    end else begin
      y1_valid <= sb_valid[SQ_STAGES];
    end
    y1_degen <= sbo.degen;
    y1_c     <= sbo.c;
    for (int i = 0; i < 6; i++) begin
      y1_tr[i] <= 64'($signed(sbo.p[i])) * 64'(sbo.co);
    end
    for (int i = 0; i < 3; i++) begin
      y1_qr[i] <= 64'($signed(sbo.k[i])) * $signed({32'd0, sb_r[SQ_STAGES][31:0]});
    end
  end

  // stage y2: round back to Q30
  logic               y2_valid;
  logic               y2_degen;
  logic signed [31:0] y2_c;
  logic signed [35:0] y2_t [6];
  logic signed [35:0] y2_q [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      y2_valid <= 1'b0;
    end else begin
      y2_valid <= y1_valid;
    end
    y2_degen <= y1_degen;
    y2_c     <= y1_c;
    for (int i = 0; i < 6; i++) begin
      y2_t[i] <= rnd30(y1_tr[i]);
    end
    for (int i = 0; i < 3; i++) begin
      y2_q[i] <= rnd30(y1_qr[i]);
    end
  end

  // stage y3: Rodrigues matrix entries, row major
  logic               y3_valid;
  logic               y3_degen;
  logic signed [35:0] y3_m [9];
  logic signed [35:0] cw;
  assign cw = 36'(y2_c);
  always_ff @(posedge clk) begin
    if (rst) begin
      y3_valid <= 1'b0;
    end else begin
      y3_valid <= y2_valid;
    end
    y3_degen <= y2_degen;
    y3_m[0] <= y2_t[0] + cw;
    y3_m[4] <= y2_t[1] + cw;
    y3_m[8] <= y2_t[2] + cw;
    y3_m[1] <= y2_t[3] - y2_q[2];
    y3_m[3] <= y2_t[3] + y2_q[2];
    y3_m[2] <= y2_t[4] + y2_q[1];
    y3_m[6] <= y2_t[4] - y2_q[1];
    y3_m[5] <= y2_t[5] - y2_q[0];
    y3_m[7] <= y2_t[5] + y2_q[0];
  end

  // output beat: format conversion or identity
  logic signed [15:0] diag;
  assign diag = 16'(HI);
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= y3_valid;
    end
    result.degenerate <= y3_degen;
    if (y3_degen) begin
      result.m00 <= diag;  result.m01 <= '0;    result.m02 <= '0;
      result.m10 <= '0;    result.m11 <= diag;  result.m12 <= '0;
      result.m20 <= '0;    result.m21 <= '0;    result.m22 <= diag;
    end else begin
      result.m00 <= to_out(y3_m[0]);
      result.m01 <= to_out(y3_m[1]);
      result.m02 <= to_out(y3_m[2]);
      result.m10 <= to_out(y3_m[3]);
      result.m11 <= to_out(y3_m[4]);
      result.m12 <= to_out(y3_m[5]);
      result.m20 <= to_out(y3_m[6]);
      result.m21 <= to_out(y3_m[7]);
      result.m22 <= to_out(y3_m[8]);
    end
  end

  // degenerate beats carry the identity
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.m01 == 16'sd0 && result.m10 == 16'sd0 && result.m02 == 16'sd0 &&
       result.m20 == 16'sd0 && result.m12 == 16'sd0 && result.m21 == 16'sd0 &&
       result.m00 == diag && result.m11 == diag && result.m22 == diag))
    else $error("degenerate beat is not the identity");

  // diagonal entries saturate to plus or minus one
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (37'(result.m00) <= HI && 37'(result.m00) >= LO &&
              37'(result.m11) <= HI && 37'(result.m11) >= LO &&
              37'(result.m22) <= HI && 37'(result.m22) >= LO))
    else $error("diagonal entry out of range");

  // off-diagonal entries saturate to plus or minus one
  a_offdiag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (37'(result.m01) <= HI && 37'(result.m01) >= LO &&
              37'(result.m10) <= HI && 37'(result.m10) >= LO &&
              37'(result.m02) <= HI && 37'(result.m02) >= LO &&
              37'(result.m20) <= HI && 37'(result.m20) >= LO &&
              37'(result.m12) <= HI && 37'(result.m12) >= LO &&
              37'(result.m21) <= HI && 37'(result.m21) >= LO))
    else $error("off-diagonal entry out of range");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the normal-to-normal rotation matrix block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import rmbn_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 108;
  localparam int STALL_LIMIT = 4000;
  localparam longint Q30 = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  vec_t vec = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic done;
  mat_t result;

  // local copy of the flip register
  logic flip_mode;
  mat_t mat_queue[$];
  int errors = 0;
  int idle_cycles = 0;

  rotation_matrix_between_normals #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .vec(vec),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // divide rounding half away from zero
  function automatic longint div_away(longint num, longint unsigned den);
    longint unsigned r;
    r = (abs64(num) + den / 2) / den;
    return num < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint shift_away(longint v, int k);
    longint unsigned r;
    if (k == 0) return v;
    r = (abs64(v) + (64'd1 << (k - 1))) >> k;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul30(longint a, longint b);
    return shift_away(a * b, 30);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v30);
    longint v;
    v = shift_away(v30, 30 - FRAC);
    v = sat(v, -(64'sd1 << FRAC), 64'sd1 << FRAC);
    v = sat(v, -32768, 32767);
    return v[15:0];
  endfunction

  // expected rotation matrix for one vector pair
  function automatic mat_t rodrigues(vec_t v, logic flip);
    longint a[3], b[3], u[3], k[3], m[9];
    longint d, c, s, co;
    longint unsigned n, un, uu;
    mat_t r;
    a[0] = v.base_x; a[1] = v.base_y; a[2] = v.base_z;
    b[0] = v.rot_x;  b[1] = v.rot_y;  b[2] = v.rot_z;
    d = b[0] * a[0] + b[1] * a[1] + b[2] * a[2];
    if (flip && d < 0) begin
      for (int i = 0; i < 3; i++) a[i] = -a[i];
      d = -d;
    end
    u[0] = b[1] * a[2] - b[2] * a[1];
    u[1] = b[2] * a[0] - b[0] * a[2];
    u[2] = b[0] * a[1] - b[1] * a[0];
    if (u[0] == 0 && u[1] == 0 && u[2] == 0) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? Q30 : 0;
      r.degenerate = 1'b1;
    end else begin
      n = int_sqrt(longint'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2])
                   * longint'(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]));
      uu = abs64(u[0]) * abs64(u[0]) + abs64(u[1]) * abs64(u[1])
         + abs64(u[2]) * abs64(u[2]);
      un = int_sqrt(uu);
      c = sat(div_away(d * Q30, n), -Q30, Q30);
      for (int i = 0; i < 3; i++) k[i] = sat(div_away(u[i] * Q30, un), -Q30, Q30);
      s = int_sqrt(longint'(Q30 * Q30 - c * c));
      co = Q30 - c;
      m[0] = qmul30(qmul30(k[0], k[0]), co) + c;
      m[4] = qmul30(qmul30(k[1], k[1]), co) + c;
      m[8] = qmul30(qmul30(k[2], k[2]), co) + c;
      m[1] = qmul30(qmul30(k[0], k[1]), co) - qmul30(k[2], s);
      m[3] = qmul30(qmul30(k[1], k[0]), co) + qmul30(k[2], s);
      m[2] = qmul30(qmul30(k[0], k[2]), co) + qmul30(k[1], s);
      m[6] = qmul30(qmul30(k[2], k[0]), co) - qmul30(k[1], s);
      m[5] = qmul30(qmul30(k[1], k[2]), co) - qmul30(k[0], s);
      m[7] = qmul30(qmul30(k[2], k[1]), co) + qmul30(k[0], s);
      r.degenerate = 1'b0;
    end
    r.m00 = to_q14(m[0]); r.m01 = to_q14(m[1]); r.m02 = to_q14(m[2]);
    r.m10 = to_q14(m[3]); r.m11 = to_q14(m[4]); r.m12 = to_q14(m[5]);
    r.m20 = to_q14(m[6]); r.m21 = to_q14(m[7]); r.m22 = to_q14(m[8]);
    return r;
  endfunction

  // send one beat after a random gap; start stays high for a following beat
  task automatic send_pair(vec_t v, bit allow_gap = 1);
    int gap;
    gap = allow_gap ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vec <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    mat_queue = {mat_queue, rodrigues(v, flip_mode)};
    @(negedge clk);
  endtask

  // wait for all results, then let the pipe drain
  task automatic drain();
    start <= 1'b0;
    while (mat_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_flip(logic val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    flip_mode = val;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_t rand_pair();
    vec_t v;
    int sel;
    int sc;
    v.base_x = 16'($urandom); v.base_y = 16'($urandom); v.base_z = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // parallel or antiparallel, scaled
      sc = $urandom_range(0, 1) ? 1 : -1;
      v.base_x = $signed(16'($urandom)) >>> 2;
      v.base_y = $signed(16'($urandom)) >>> 2;
      v.base_z = $signed(16'($urandom)) >>> 2;
      v.rot_x = 16'(v.base_x * sc * 2); v.rot_y = 16'(v.base_y * sc * 2);
      v.rot_z = 16'(v.base_z * sc * 2);
    end else if (sel == 1) begin
      v.base_x = rand_comp(); v.base_y = rand_comp(); v.base_z = rand_comp();
      v.rot_x = rand_comp(); v.rot_y = rand_comp(); v.rot_z = rand_comp();
    end else begin
      v.rot_x = 16'($urandom); v.rot_y = 16'($urandom); v.rot_z = 16'($urandom);
    end
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    mat_t want;
    if (!rst && done) begin
      if (mat_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        want = mat_queue.pop_front();
        if (result !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, result);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic vec_t mk(int bx, int by, int bz, int rx, int ry, int rz);
    vec_t v;
    v.base_x = 16'(bx); v.base_y = 16'(by); v.base_z = 16'(bz);
    v.rot_x = 16'(rx);  v.rot_y = 16'(ry);  v.rot_z = 16'(rz);
    return v;
  endfunction

  // field extremes, zero, parallel and obtuse cases
  task automatic test_directed();
    send_pair(mk(0, 0, 0, 0, 0, 0));
    send_pair(mk(16384, 0, 0, 16384, 0, 0));
    send_pair(mk(16384, 0, 0, -16384, 0, 0));
    send_pair(mk(16384, 0, 0, 0, 16384, 0));
    send_pair(mk(0, 16384, 0, 0, 0, 16384));
    send_pair(mk(-32768, -32768, -32768, 32767, 32767, 32767));
    send_pair(mk(-32768, 0, 0, 0, -32768, 0));
    send_pair(mk(32767, -32768, 1, -1, 32767, -32768));
    send_pair(mk(-32768, 5, 0, 32767, 0, 0));
    send_pair(mk(1, 0, 0, 0, 1, 0));
    send_pair(mk(1, 1, 0, -1, 0, 0));
    send_pair(mk(16384, 1, 0, 16384, 0, 0));
    send_pair(mk(-16384, 100, 7, 16000, 50, -3));
    send_pair(mk(-1, -1, -1, -1, -1, -1));
    send_pair(mk(32767, 32767, 32767, -32768, -32768, -32767));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_pair(rand_pair(), i % 200 < 150);
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    flip_mode = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    write_flip(1'b0);
    test_directed();
    test_random(350);
    write_flip(1'b1);
    test_random(350);
    write_flip(1'b0);
    write_flip(1'b1);
    test_random(370);
    drain();
    if (errors == 0 && mat_queue.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
